FILE: design/annealing_temperature_scheduler_unit_macros.svh
// Assertion macros shared by the annealing temperature scheduler RTL.
// Expects clk and rst_n in the scope of every use; depends on nothing else.
`ifndef ANNEALING_TEMPERATURE_SCHEDULER_UNIT_MACROS_SVH
`define ANNEALING_TEMPERATURE_SCHEDULER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ATS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ATS_ASSERT_SAME(lbl, ante, cons, msg)
`define ATS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/ats_pkg.sv
// Types and constants of the annealing temperature scheduler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;

  typedef enum logic [1:0] {
    SCHED_HEAT = 2'd0,
    SCHED_COOL = 2'd1,
    SCHED_WARM = 2'd2,
    SCHED_SAMC = 2'd3
  } sched_t;

  localparam logic MODE_BEGIN  = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCHEDULE          = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_TEMPERATURE = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TARGET_RATE       = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DECAY_RATE        = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ENERGY_FLAT_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RATE_FLOOR        = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FLOOR_TEMPERATURE = 3'd6;

  localparam logic [31:0] START_TEMP_RESET = 32'd1310720;

  localparam logic [16:0] HEAT_UP_Q16   = 17'd72090;
  localparam logic [16:0] HEAT_DOWN_Q16 = 17'd58982;
  localparam logic [16:0] COOL_LIMIT    = 17'd3277;
  localparam logic [3:0]  COOL_STOP     = 4'd5;
  localparam logic [3:0]  SAMC_STOP     = 4'd10;
  localparam logic [3:0]  STALL_MAX     = 4'd15;

  typedef struct packed {
    logic               mode;
    logic [16:0]        success_rate;
    logic signed [31:0] energy;
  } in_item_t;

  typedef struct packed {
    logic [31:0] temperature;
    logic        keep_going;
  } out_item_t;

  typedef struct packed {
    sched_t      schedule;
    logic [31:0] start_temperature;
    logic [16:0] target_rate;
    logic [16:0] decay_rate;
    logic [31:0] energy_flat_limit;
    logic [16:0] rate_floor;
    logic [31:0] floor_temperature;
  } cfg_t;

endpackage
`default_nettype wire

FILE: design/annealing_temperature_scheduler_unit.sv
// Top level of the annealing temperature scheduler: handshakes and pipeline registers.
// Depends on ats_pkg, ats_cfg_regs and ats_update.
//
// Each input transaction yields exactly one result transaction. A transaction is
// captured in an input register and then goes through the temperature update (one
// TEMP_WIDTH by 17 bit multiply, saturation and the stall compares) into the result
// register; one transaction is taken every cycle while the result is not stalled.
// The schedule state is written in the same cycle the result register loads, which
// lets the next report use it at once. A stalled result holds the update stage, and
// input stall follows. Configuration writes are always ready; write them only
// while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module annealing_temperature_scheduler_unit
  import ats_pkg::*;
#(
  parameter int TEMP_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire in_item_t                   in_item,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output out_item_t                       out_item,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0]                cfg_data
);

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      out_free;
  logic      fire;
  logic      accept;

  assign cfg_ready = 1'b1;

  ats_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ats_update #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_update (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_free) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: design/ats_cfg_regs.sv
// Configuration register file of the annealing temperature scheduler.
// Depends on ats_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none
module ats_cfg_regs
  import ats_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
  input  wire logic [31:0]                wr_data,
  output cfg_t                            cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.schedule          <= SCHED_COOL;
      cfg_r.start_temperature <= START_TEMP_RESET;
      cfg_r.target_rate       <= 17'd32768;
      cfg_r.decay_rate        <= 17'd65503;
      cfg_r.energy_flat_limit <= 32'd32768;
      cfg_r.rate_floor        <= 17'd655;
      cfg_r.floor_temperature <= 32'd1310720;
    end else if (wr_en) begin
      case (wr_index)
        CFG_SCHEDULE:          cfg_r.schedule          <= sched_t'(wr_data[1:0]);
        CFG_START_TEMPERATURE: cfg_r.start_temperature <= wr_data;
        CFG_TARGET_RATE:       cfg_r.target_rate       <= wr_data[16:0];
        CFG_DECAY_RATE:        cfg_r.decay_rate        <= wr_data[16:0];
        CFG_ENERGY_FLAT_LIMIT: cfg_r.energy_flat_limit <= wr_data;
        CFG_RATE_FLOOR:        cfg_r.rate_floor        <= wr_data[16:0];
        CFG_FLOOR_TEMPERATURE: cfg_r.floor_temperature <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: design/ats_update.sv
// Schedule state and combinational temperature update of the scheduler.
// Depends on ats_pkg and on the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "annealing_temperature_scheduler_unit_macros.svh"
module ats_update
  import ats_pkg::*;
#(
  parameter int TEMP_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  output out_item_t     result
);

  localparam int PW = TEMP_WIDTH + 17;
  localparam int CW = (TEMP_WIDTH > 32) ? TEMP_WIDTH : 32;
  localparam logic [TEMP_WIDTH-1:0] TEMP_MAX = {TEMP_WIDTH{1'b1}};
  localparam logic [CW-1:0] TEMP_MAX_EXT = CW'(TEMP_MAX);
  localparam logic [CW-1:0] START_EXT = CW'(START_TEMP_RESET);
  localparam logic [TEMP_WIDTH-1:0] TEMP_RESET =
    (START_EXT > TEMP_MAX_EXT) ? TEMP_MAX : TEMP_WIDTH'(START_EXT);

  logic [TEMP_WIDTH-1:0] temp_r, temp_nxt;
  logic signed [31:0]    last_energy_r, last_energy_nxt;
  logic [3:0]            energy_stalls_r, energy_stalls_nxt;
  logic [3:0]            rate_stalls_r, rate_stalls_nxt;

  logic [16:0]           mul;
  logic                  do_scale;
  logic [PW-1:0]         product;
  logic [TEMP_WIDTH:0]   scaled;
  logic [TEMP_WIDTH-1:0] scaled_sat;
  logic [CW-1:0]         start_ext;
  logic [TEMP_WIDTH-1:0] start_sat;
  logic signed [32:0]    energy_diff;
  logic [32:0]           energy_delta;
  logic [32:0]           energy_limit;
  logic [16:0]           rate_limit;
  logic                  is_samc;
  logic                  keep;

  function automatic logic [3:0] bump(input logic [3:0] c);
    return (c < STALL_MAX) ? c + 4'd1 : STALL_MAX;
  endfunction

  assign product    = PW'(temp_r) * PW'(mul);
  assign scaled     = product[PW-1:16];
  assign scaled_sat = scaled[TEMP_WIDTH] ? TEMP_MAX : scaled[TEMP_WIDTH-1:0];

  assign start_ext = CW'(cfg.start_temperature);
  assign start_sat = (start_ext > TEMP_MAX_EXT) ? TEMP_MAX : TEMP_WIDTH'(start_ext);

  assign energy_diff  = {last_energy_r[31], last_energy_r} - {item.energy[31], item.energy};
  assign energy_delta = energy_diff[32] ? 33'(-energy_diff) : 33'(energy_diff);
  assign is_samc      = (cfg.schedule == SCHED_SAMC);
  assign energy_limit = is_samc ? {1'b0, cfg.energy_flat_limit} : 33'(COOL_LIMIT);
  assign rate_limit   = is_samc ? cfg.rate_floor : COOL_LIMIT;

  always_comb begin
    mul               = cfg.decay_rate;
    do_scale          = 1'b0;
    temp_nxt          = temp_r;
    last_energy_nxt   = last_energy_r;
    energy_stalls_nxt = energy_stalls_r;
    rate_stalls_nxt   = rate_stalls_r;
    keep              = 1'b1;
    if (item.mode == MODE_BEGIN) begin
      temp_nxt          = start_sat;
      last_energy_nxt   = '0;
      energy_stalls_nxt = '0;
      rate_stalls_nxt   = '0;
    end else begin
      case (cfg.schedule)
        SCHED_HEAT: begin
          if (item.success_rate < cfg.target_rate) begin
            mul      = HEAT_UP_Q16;
            do_scale = 1'b1;
          end else if (item.success_rate > cfg.target_rate) begin
            mul      = HEAT_DOWN_Q16;
            do_scale = 1'b1;
          end
        end
        SCHED_COOL, SCHED_SAMC: begin
          do_scale = 1'b1;
          if (energy_delta <= energy_limit) begin
            energy_stalls_nxt = bump(energy_stalls_r);
          end else if (!is_samc) begin
            energy_stalls_nxt = '0;
          end
          last_energy_nxt = item.energy;
          if (item.success_rate <= rate_limit) begin
            rate_stalls_nxt = bump(rate_stalls_r);
          end else if (!is_samc) begin
            rate_stalls_nxt = '0;
          end
        end
        default: begin
        end
      endcase
      if (do_scale) begin
        temp_nxt = scaled_sat;
      end
      case (cfg.schedule)
        SCHED_COOL: begin
          keep = (rate_stalls_nxt < COOL_STOP) && (energy_stalls_nxt < COOL_STOP);
        end
        SCHED_SAMC: begin
          keep = (rate_stalls_nxt < SAMC_STOP) && (energy_stalls_nxt < SAMC_STOP) &&
                 (CW'(temp_nxt) >= CW'(cfg.floor_temperature));
        end
        default: begin
          keep = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r          <= TEMP_RESET;
      last_energy_r   <= '0;
      energy_stalls_r <= '0;
      rate_stalls_r   <= '0;
    end else if (fire) begin
      temp_r          <= temp_nxt;
      last_energy_r   <= last_energy_nxt;
      energy_stalls_r <= energy_stalls_nxt;
      rate_stalls_r   <= rate_stalls_nxt;
    end
  end

  assign result.temperature = 32'(temp_nxt);
  assign result.keep_going  = keep;

  `ATS_ASSERT_NEXT(a_begin_clears, fire && (item.mode == MODE_BEGIN),
    (energy_stalls_r == 4'd0) && (rate_stalls_r == 4'd0) && (last_energy_r == 32'sd0),
    "Begin transaction did not clear the run state.")
  `ATS_ASSERT_NEXT(a_warm_holds,
    fire && (item.mode == MODE_REPORT) && (cfg.schedule == SCHED_WARM),
    $stable(temp_r) && $stable(energy_stalls_r) && $stable(rate_stalls_r),
    "Warm report changed the schedule state.")
  `ATS_ASSERT_NEXT(a_heat_keeps_counters,
    fire && (item.mode == MODE_REPORT) && (cfg.schedule == SCHED_HEAT),
    $stable(last_energy_r) && $stable(energy_stalls_r) && $stable(rate_stalls_r),
    "Heat report changed the stall counters or the energy.")
  `ATS_ASSERT_SAME(a_stop_only_when_cooling, fire && !result.keep_going,
    (item.mode == MODE_REPORT) &&
    ((cfg.schedule == SCHED_COOL) || (cfg.schedule == SCHED_SAMC)),
    "Stop flag raised outside a cooling report.")

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for annealing_temperature_scheduler_unit.
// Drives directed and random transactions with random stalls and checks each result
// against a cycle-free predictor; depends on ats_pkg and the RTL under design/.
`timescale 1ns / 1ps
module tb;
  import ats_pkg::*;

  localparam int NUM_DIRECTED    = 23;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PAUSE_PHASE     = 6;
  localparam int RX_HOLD_AT      = 300;
  localparam int RX_HOLD_LEN     = 200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [2:0]  phase;
    logic        mode;
    logic [16:0] rate;
    logic [31:0] energy;
    logic        fixed;
    logic [31:0] temp;
    logic        keep;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{3'd0, MODE_REPORT, 17'd0,      32'h0000_0000, 1'b1, 32'd1310060,   1'b1},
    '{3'd0, MODE_BEGIN,  17'd0,      32'h0000_0000, 1'b1, 32'd1310720,   1'b1},
    '{3'd0, MODE_REPORT, 17'h1FFFF,  32'h7FFF_FFFF, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd65536,  32'h8000_0000, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd3277,   32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd3278,   32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd0,      32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd0,      32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd0,      32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd0,      32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd0, MODE_REPORT, 17'd0,      32'h8000_0CCD, 1'b0, 32'd0,         1'b0},
    '{3'd1, MODE_BEGIN,  17'd0,      32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{3'd1, MODE_REPORT, 17'd0,      32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1},
    '{3'd1, MODE_REPORT, 17'h1FFFF,  32'h0000_0000, 1'b0, 32'd0,         1'b0},
    '{3'd1, MODE_REPORT, 17'd32768,  32'h0000_0000, 1'b0, 32'd0,         1'b0},
    '{3'd2, MODE_BEGIN,  17'd0,      32'h0000_0000, 1'b1, 32'd0,         1'b1},
    '{3'd2, MODE_REPORT, 17'd5,      32'd12345,     1'b1, 32'd0,         1'b1},
    '{3'd3, MODE_BEGIN,  17'd0,      32'h0000_0000, 1'b1, 32'd1310720,   1'b1},
    '{3'd3, MODE_REPORT, 17'd0,      32'h0000_0000, 1'b1, 32'd0,         1'b0},
    '{3'd3, MODE_REPORT, 17'd1,      32'h0000_0001, 1'b0, 32'd0,         1'b0},
    '{3'd4, MODE_BEGIN,  17'd0,      32'h0000_0000, 1'b1, 32'd1310720,   1'b1},
    '{3'd4, MODE_REPORT, 17'h1FFFF,  32'h7FFF_FFFF, 1'b0, 32'd0,         1'b0},
    '{3'd4, MODE_REPORT, 17'd0,      32'h8000_0000, 1'b0, 32'd0,         1'b0}
  };

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  in_item_t                   in_item = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  out_item_t                  out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [31:0]                cfg_data = '0;

  logic      row_fixed = 1'b0;
  out_item_t row_fixed_res = '0;

  out_item_t   expected_temps [$];
  int unsigned n_errors = 0;
  bit          no_idle = 1'b0;
  logic [16:0] cur_target = 17'd32768;
  logic [16:0] cur_rfloor = 17'd655;
  logic [31:0] last_energy_sent = '0;

  sched_t            sched_now = SCHED_COOL;
  logic [31:0]       start_t = START_TEMP_RESET;
  logic [16:0]       target_r = 17'd32768;
  logic [16:0]       decay_r = 17'd65503;
  logic [31:0]       eflat_lim = 32'd32768;
  logic [16:0]       rate_flr = 17'd655;
  logic [31:0]       floor_t = 32'd1310720;
  logic [31:0]       temp_now = START_TEMP_RESET;
  logic signed [31:0] energy_prev = '0;
  logic [3:0]        estall_cnt = '0;
  logic [3:0]        rstall_cnt = '0;

  annealing_temperature_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] scaled_temp(input logic [31:0] t, input logic [16:0] mul);
    logic [63:0] prod;
    prod = {32'd0, t} * {47'd0, mul};
    prod = prod >> 16;
    if (prod > 64'h0000_0000_FFFF_FFFF) return 32'hFFFF_FFFF;
    return prod[31:0];
  endfunction

  task automatic apply_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] d);
    case (idx)
      CFG_SCHEDULE:          sched_now = sched_t'(d[1:0]);
      CFG_START_TEMPERATURE: start_t = d;
      CFG_TARGET_RATE:       target_r = d[16:0];
      CFG_DECAY_RATE:        decay_r = d[16:0];
      CFG_ENERGY_FLAT_LIMIT: eflat_lim = d;
      CFG_RATE_FLOOR:        rate_flr = d[16:0];
      CFG_FLOOR_TEMPERATURE: floor_t = d;
      default: ;
    endcase
  endtask

  task automatic next_schedule(input in_item_t it, output out_item_t res);
    longint diff;
    longint elim;
    longint rlim;
    longint rate;
    logic   samc_run;
    res.keep_going = 1'b1;
    if (it.mode == MODE_BEGIN) begin
      temp_now = start_t;
      energy_prev = '0;
      estall_cnt = '0;
      rstall_cnt = '0;
    end else begin
      case (sched_now)
        SCHED_HEAT: begin
          if (it.success_rate < target_r) temp_now = scaled_temp(temp_now, HEAT_UP_Q16);
          else if (it.success_rate > target_r) temp_now = scaled_temp(temp_now, HEAT_DOWN_Q16);
        end
        SCHED_COOL, SCHED_SAMC: begin
          samc_run = (sched_now == SCHED_SAMC);
          diff = longint'($signed(energy_prev)) - longint'($signed(it.energy));
          if (diff < 0) diff = -diff;
          rate = longint'(it.success_rate);
          if (samc_run) begin
            elim = longint'(eflat_lim);
            rlim = longint'(rate_flr);
          end else begin
            elim = longint'(COOL_LIMIT);
            rlim = longint'(COOL_LIMIT);
          end
          temp_now = scaled_temp(temp_now, decay_r);
          if (diff <= elim) begin
            if (estall_cnt != STALL_MAX) estall_cnt = estall_cnt + 4'd1;
          end else if (!samc_run) begin
            estall_cnt = '0;
          end
          energy_prev = it.energy;
          if (rate <= rlim) begin
            if (rstall_cnt != STALL_MAX) rstall_cnt = rstall_cnt + 4'd1;
          end else if (!samc_run) begin
            rstall_cnt = '0;
          end
          if (samc_run) begin
            res.keep_going = (rstall_cnt < SAMC_STOP) && (estall_cnt < SAMC_STOP) &&
                             (temp_now >= floor_t);
          end else begin
            res.keep_going = (rstall_cnt < COOL_STOP) && (estall_cnt < COOL_STOP);
          end
        end
        default: ;
      endcase
    end
    res.temperature = temp_now;
  endtask

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        got = out_item;
        if (expected_temps.size() == 0) begin
          flag_error($sformatf("unexpected result temperature %h keep %b",
                               got.temperature, got.keep_going));
        end else begin
          want = expected_temps.pop_front();
          if (got.temperature !== want.temperature || got.keep_going !== want.keep_going)
            flag_error($sformatf("expected temperature %h keep %b, got temperature %h keep %b",
                                 want.temperature, want.keep_going,
                                 got.temperature, got.keep_going));
        end
      end
      if (in_valid && !in_stall) begin
        next_schedule(in_item, want);
        if (row_fixed) want = row_fixed_res;
        expected_temps.push_back(want);
      end
    end
  end

  int unsigned rx_taken = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_burst = 0;
  bit          rx_held = 1'b0;

  always @(posedge clk) begin
    if (out_valid && !out_stall) rx_taken++;
    if (rx_hold != 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else if (!rx_held && rx_taken >= RX_HOLD_AT) begin
      rx_held = 1'b1;
      rx_hold = RX_HOLD_LEN;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (rx_burst != 0) begin
      rx_burst--;
    end else begin
      rx_burst = $urandom_range(0, 18);
      out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input in_item_t it, input logic fixed, input out_item_t fixed_res);
    in_valid <= 1'b1;
    in_item <= it;
    row_fixed <= fixed;
    row_fixed_res <= fixed_res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_temps.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input sched_t sc, input logic [31:0] st, input logic [16:0] tg,
                            input logic [16:0] dc, input logic [31:0] ef,
                            input logic [16:0] rf, input logic [31:0] tf);
    cfg_write(CFG_SCHEDULE, {30'd0, sc});
    cfg_write(CFG_START_TEMPERATURE, st);
    cfg_write(CFG_TARGET_RATE, {15'd0, tg});
    cfg_write(CFG_DECAY_RATE, {15'd0, dc});
    cfg_write(CFG_ENERGY_FLAT_LIMIT, ef);
    cfg_write(CFG_RATE_FLOOR, {15'd0, rf});
    cfg_write(CFG_FLOOR_TEMPERATURE, tf);
    cfg_valid <= 1'b0;
    cur_target = tg;
    cur_rfloor = rf;
  endtask

  task automatic directed_config(input logic [2:0] phase);
    case (phase)
      3'd1: set_config(SCHED_HEAT, 32'hFFFF_FFFF, 17'd32768, 17'd65503, 32'd32768, 17'd655,
                       32'd1310720);
      3'd2: set_config(SCHED_WARM, 32'd0, 17'd65536, 17'd65536, 32'd32768, 17'd655,
                       32'd1310720);
      3'd3: set_config(SCHED_SAMC, 32'd1310720, 17'd32768, 17'd0, 32'd0, 17'd0,
                       32'hFFFF_FFFF);
      default: set_config(SCHED_SAMC, 32'd1310720, 17'd0, 17'h1FFFF, 32'hFFFF_FFFF,
                          17'h1FFFF, 32'd0);
    endcase
  endtask

  function automatic logic [31:0] pick_wide();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom >> $urandom_range(0, 20);
    endcase
    return v;
  endfunction

  function automatic logic [16:0] pick_frac();
    logic [16:0] v;
    case ($urandom_range(0, 5))
      0: v = 17'd0;
      1: v = 17'd65536;
      2: v = 17'h1FFFF;
      default: v = 17'($urandom_range(0, 65536));
    endcase
    return v;
  endfunction

  function automatic logic [16:0] pick_decay();
    logic [16:0] v;
    case ($urandom_range(0, 7))
      0: v = 17'd0;
      1: v = 17'd65536;
      2: v = 17'h1FFFF;
      default: v = 17'($urandom_range(58000, 65535));
    endcase
    return v;
  endfunction

  function automatic logic [16:0] pick_rate();
    logic [16:0] v;
    case ($urandom_range(0, 7))
      0: v = 17'd0;
      1: v = 17'd65536;
      2: v = 17'h1FFFF;
      3: v = 17'(COOL_LIMIT + $urandom_range(0, 1));
      4: v = 17'(cur_target + $urandom_range(0, 2) - 1);
      5: v = 17'(cur_rfloor + $urandom_range(0, 2) - 1);
      6: v = 17'($urandom_range(0, 65536));
      default: v = 17'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_energy(input logic [31:0] prev);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = prev;
      2, 3, 4: v = prev + $urandom_range(0, 8000) - 4000;
      5: v = prev + $urandom_range(0, 160000) - 80000;
      6: v = 32'h7FFF_FFFF;
      7: v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic random_run(input int p);
    in_item_t it;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if ((n == 0 && p % 2 == 0) || $urandom_range(0, 29) == 0) it.mode = MODE_BEGIN;
      else it.mode = MODE_REPORT;
      it.success_rate = pick_rate();
      it.energy = pick_energy(last_energy_sent);
      last_energy_sent = it.energy;
      send(it, 1'b0, '0);
      if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) drain();
      else idle_gap();
    end
  endtask

  initial begin
    stim_row_t   row;
    logic [2:0]  phase_now;
    in_item_t    it;
    out_item_t   fx;
    logic [1:0]  sc;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    phase_now = 3'd0;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.phase != phase_now) begin
        drain();
        directed_config(row.phase);
        phase_now = row.phase;
      end
      it.mode = row.mode;
      it.success_rate = row.rate;
      it.energy = row.energy;
      fx.temperature = row.temp;
      fx.keep_going = row.keep;
      send(it, row.fixed, fx);
      idle_gap();
    end
    drain();
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) no_idle = 1'b1;
      sc = p[1:0];
      set_config(sched_t'(sc), pick_wide(), pick_frac(), pick_decay(), pick_wide(),
                 pick_frac(), pick_wide());
      random_run(p);
      drain();
    end
    repeat (8) @(posedge clk);
    if (expected_temps.size() != 0) flag_error("results still outstanding at end of run");
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
